/* hw/rtl/shared_exclusive_lock_manager_macros.svh */
// assertion macros for the shared/exclusive lock manager
// expects clk_i and rst_ni in the scope of each use
`ifndef SHARED_EXCLUSIVE_LOCK_MANAGER_MACROS_SVH
`define SHARED_EXCLUSIVE_LOCK_MANAGER_MACROS_SVH

// condition holds at every edge out of reset
`define SELM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle
`define SELM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SELM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/selm_pkg.sv */
// shared types and constants of the shared/exclusive lock manager
// no dependencies
package selm_pkg;

  localparam int unsigned PEER_W   = 6;
  localparam int unsigned SERIAL_W = 64;
  localparam int unsigned PT_W     = PEER_W + 1;
  localparam int unsigned SH_W     = 7;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [SH_W-1:0] SHARER_MAX = 7'd127;

  typedef enum logic [1:0] {
    MODE_FREE   = 2'd0,
    MODE_SHARED = 2'd1,
    MODE_EXCL   = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT  = 3'd0,
    KIND_UACK   = 3'd1,
    KIND_QUEUED = 3'd2,
    KIND_BLOCK  = 3'd3,
    KIND_FULL   = 3'd4
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // capture the input transfer
    logic exec;    // decide the request, emit its first result
    logic grant;   // grant the waiter at the queue head
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic exec_drain;  // the pending request frees the lock with waiters queued
    logic grant_more;  // another waiter follows the current head grant
  } sts_t;

endpackage

/* hw/rtl/selm_ctrl.sv */
// sequencing state machine of the shared/exclusive lock manager
// depends on selm_pkg and the assertion macro header
`include "shared_exclusive_lock_manager_macros.svh"

module selm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  selm_pkg::sts_t   sts_i,
  output selm_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_GRANT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.exec_drain ? ST_READ : ST_IDLE;
        end
      end
      // queue memory read of head and next entry
      ST_READ: begin
        state_d = ST_GRANT;
      end
      ST_GRANT: begin
        if (sts_i.out_free) begin
          cmd_o.grant = 1'b1;
          state_d     = sts_i.grant_more ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SELM_ASSERT(a_cmd_onehot0, $onehot0({cmd_o.accept, cmd_o.exec, cmd_o.grant}), "overlapping commands")
  `SELM_ASSERT_NXT(a_accept_exec, cmd_o.accept, !in_ready_o, "input taken while busy")

endmodule

/* hw/rtl/selm_dp.sv */
// datapath of the shared/exclusive lock manager: lock state, wait queue memory,
// request decision and output register; depends on selm_pkg and the macro header
`include "shared_exclusive_lock_manager_macros.svh"

module selm_dp #(
  parameter int unsigned WAIT_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [selm_pkg::PEER_W-1:0]         cfg_wdata_i,
  input  logic                                in_func_i,
  input  logic [selm_pkg::IN_DATA_W-1:0]      in_data_i,
  input  selm_pkg::cmd_t                      cmd_i,
  output selm_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [selm_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [selm_pkg::KIND_W-1:0]         out_kind_o,
  output logic                                out_last_o
);

  localparam int unsigned IdxW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(WAIT_DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(WAIT_DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(WAIT_DEPTH - 1);

  localparam int unsigned PW = selm_pkg::PEER_W;
  localparam int unsigned SW = selm_pkg::SERIAL_W;
  localparam int unsigned HW = selm_pkg::SH_W;

  // configuration
  logic [PW-1:0] own_rank_q;

  // captured request
  logic          func_q;
  logic [PW-1:0] req_q;
  logic          excl_q;
  logic [SW-1:0] serial_q;
  logic          settled_q;

  // lock state
  selm_pkg::mode_e mode_q, mode_d;
  logic [HW-1:0]   sh_q, sh_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;

  // wait queue memory
  logic [selm_pkg::PT_W-1:0] mem_pt  [WAIT_DEPTH];
  logic [SW-1:0]             mem_ser [WAIT_DEPTH];
  logic [selm_pkg::PT_W-1:0] rd_pt_a_q, rd_pt_b_q;
  logic [SW-1:0]             rd_ser_q;

  // output register
  logic          out_valid_q;
  logic [2:0]    kind_q;
  logic [PW-1:0] peer_q;
  logic [SW-1:0] oser_q;
  logic          local_q;
  logic          last_q;

  // combinational decision
  logic            emit;
  selm_pkg::kind_e emit_kind;
  logic [PW-1:0]   emit_peer;
  logic [SW-1:0]   emit_serial;
  logic            emit_last;
  logic            q_we;
  logic [SumW-1:0] tail_sum;
  logic [IdxW-1:0] tail_idx;
  logic [IdxW-1:0] head_nxt;
  logic [HW-1:0]   sh_inc, sh_dec;
  logic            freed;
  logic            lock_ok;
  logic            grant_last;

  assign head_nxt = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail_idx = (tail_sum >= DepthSum) ? IdxW'(tail_sum - DepthSum) : IdxW'(tail_sum);
  assign sh_inc   = (sh_q == selm_pkg::SHARER_MAX) ? sh_q : sh_q + HW'(1);
  assign sh_dec   = (sh_q == '0) ? sh_q : sh_q - HW'(1);
  assign freed    = excl_q || (sh_dec == '0);
  assign lock_ok  = excl_q ? (mode_q == selm_pkg::MODE_FREE) : (mode_q != selm_pkg::MODE_EXCL);
  assign grant_last = rd_pt_a_q[PW] || (count_q == CntW'(1)) || rd_pt_b_q[PW];

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.exec_drain = func_q && settled_q && freed && (count_q != '0);
  assign sts_o.grant_more = !grant_last;

  always_comb begin
    emit        = 1'b0;
    emit_kind   = selm_pkg::KIND_GRANT;
    emit_peer   = req_q;
    emit_serial = serial_q;
    emit_last   = 1'b1;
    q_we        = 1'b0;
    mode_d      = mode_q;
    sh_d        = sh_q;
    head_d      = head_q;
    count_d     = count_q;
    if (cmd_i.exec) begin
      emit = 1'b1;
      if (!func_q) begin
        priority if (lock_ok) begin
          emit_kind = selm_pkg::KIND_GRANT;
          if (excl_q) begin
            mode_d = selm_pkg::MODE_EXCL;
          end else begin
            mode_d = selm_pkg::MODE_SHARED;
            sh_d   = sh_inc;
          end
        end else if (count_q == DepthCnt) begin
          emit_kind = selm_pkg::KIND_FULL;
        end else begin
          emit_kind = selm_pkg::KIND_QUEUED;
          q_we      = 1'b1;
          count_d   = count_q + CntW'(1);
        end
      end else if (!settled_q) begin
        emit_kind   = selm_pkg::KIND_BLOCK;
        emit_serial = '0;
      end else begin
        emit_kind   = selm_pkg::KIND_UACK;
        emit_serial = '0;
        emit_last   = !(freed && (count_q != '0));
        if (!excl_q) begin
          sh_d = sh_dec;
        end
        if (freed) begin
          mode_d = selm_pkg::MODE_FREE;
        end
      end
    end else if (cmd_i.grant) begin
      emit        = 1'b1;
      emit_kind   = selm_pkg::KIND_GRANT;
      emit_peer   = rd_pt_a_q[PW-1:0];
      emit_serial = rd_ser_q;
      emit_last   = grant_last;
      head_d      = head_nxt;
      count_d     = count_q - CntW'(1);
      if (rd_pt_a_q[PW]) begin
        mode_d = selm_pkg::MODE_EXCL;
      end else begin
        mode_d = selm_pkg::MODE_SHARED;
        sh_d   = sh_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_rank_q  <= '0;
      mode_q      <= selm_pkg::MODE_FREE;
      sh_q        <= '0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_rank_q <= cfg_wdata_i;
      end
      mode_q  <= mode_d;
      sh_q    <= sh_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q    <= in_func_i;
      req_q     <= in_data_i[PW-1:0];
      excl_q    <= in_data_i[PW];
      serial_q  <= in_data_i[PW+SW:PW+1];
      settled_q <= in_data_i[PW+SW+1];
    end
    if (emit) begin
      kind_q  <= emit_kind;
      peer_q  <= emit_peer;
      oser_q  <= emit_serial;
      local_q <= (emit_peer == own_rank_q);
      last_q  <= emit_last;
    end
  end

  // queue memory: one write port, reads at head and head + 1
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      mem_pt[tail_idx]  <= {excl_q, req_q};
      mem_ser[tail_idx] <= serial_q;
    end
    rd_pt_a_q <= mem_pt[head_q];
    rd_pt_b_q <= mem_pt[head_nxt];
    rd_ser_q  <= mem_ser[head_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;
  assign out_data_o  = {1'b0, local_q, oser_q, peer_q};

  `SELM_ASSERT(a_count_bound, count_q <= DepthCnt, "wait count beyond queue depth")
  `SELM_ASSERT_IMP(a_emit_slot, emit, sts_o.out_free, "result emitted over a pending one")
  `SELM_ASSERT_IMP(a_grant_nonempty, cmd_i.grant, count_q != '0, "grant from an empty queue")
  `SELM_ASSERT_NXT(a_grant_pops, cmd_i.grant, count_q == $past(count_q) - CntW'(1), "grant did not pop")

endmodule

/* hw/rtl/shared_exclusive_lock_manager.sv */
// top level of the shared/exclusive lock manager
// depends on selm_pkg, selm_ctrl and selm_dp
//
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+------------------------------------------
// s_axis   | in  | tvalid / tready      | tuser func, tdata requestor..frags_settled
// m_axis   | out | tvalid / tready      | tuser kind, tdata peer..is_local, tlast
// cfg      | in  | write enable only    | own_rank
//
// a request passes a capture and a decision state and is done before the next input
// transfer; its first result is registered at the decision; each waiter granted on an
// unlock adds a queue read and a grant state, set by the registered queue memory read
// reset clears lock mode, sharer count and queue pointers; queue memory needs no clear
// a stalled output holds the decision and grant cycles; input tready is high in idle

module shared_exclusive_lock_manager #(
  parameter int unsigned WAIT_DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration: own_rank
  input  logic                                 cfg_we_i,
  input  logic [selm_pkg::PEER_W-1:0]          cfg_wdata_i,
  // requests
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // requestor[5:0], exclusive[6], request_serial[70:7], frags_settled[71]
  input  logic [selm_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // func[0]
  input  logic                                 s_axis_tuser_i,
  // results
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // peer[5:0], grant_serial[69:6], is_local[70], zero[71]
  output logic [selm_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // kind[2:0]
  output logic [selm_pkg::KIND_W-1:0]          m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);

  selm_pkg::cmd_t cmd;
  selm_pkg::sts_t sts;

  // sequencer: idle, decide, queue read, head grant
  selm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // lock state, wait queue and result register
  selm_dp #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

/* tb/shared_exclusive_lock_manager_tb.sv */
// self-checking testbench for the shared/exclusive lock manager
// holds its own lock and wait-queue predictor and checks every result transfer against it
// depends on selm_pkg and shared_exclusive_lock_manager
`timescale 1ns / 1ps

module shared_exclusive_lock_manager_tb;

  localparam int unsigned WAIT_DEPTH      = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 400;   // long output stall to back up the block
  localparam int unsigned STALL_LIMIT     = 4000;  // cycles without any transfer
  localparam int unsigned DRAIN_CYCLES    = 40;    // settle time at the very end

  localparam int unsigned PW = selm_pkg::PEER_W;
  localparam int unsigned SW = selm_pkg::SERIAL_W;

  // request function and lock type codes
  localparam logic FUNC_LOCK   = 1'b0;
  localparam logic FUNC_UNLOCK = 1'b1;
  localparam logic LOCK_SHARED = 1'b0;
  localparam logic LOCK_EXCL   = 1'b1;

  // one request as it travels on the input side
  typedef struct packed {
    logic          func;
    logic [PW-1:0] requestor;
    logic          excl;
    logic [SW-1:0] serial;
    logic          settled;
  } lock_req_t;

  // one result as it travels on the output side
  typedef struct packed {
    logic [selm_pkg::KIND_W-1:0] kind;
    logic [PW-1:0]               peer;
    logic [SW-1:0]               serial;
    logic                        is_local;
    logic                        pad;
    logic                        last;
  } lock_result_t;

  // lock state tracker: mirrors hold mode, sharer count and the wait queue,
  // and keeps the results each accepted request is bound to produce
  class lock_outcome_book;
    selm_pkg::mode_e             hold;
    logic [selm_pkg::SH_W-1:0]   sharers;
    logic [PW-1:0]               wq_peer   [WAIT_DEPTH];
    logic                        wq_excl   [WAIT_DEPTH];
    logic [SW-1:0]               wq_serial [WAIT_DEPTH];
    int unsigned                 wq_head;
    int unsigned                 wq_count;
    logic [PW-1:0]               own_rank;
    lock_result_t                pending_results[$];
    int unsigned                 errors;
    int unsigned                 requests_seen;
    int unsigned                 results_seen;
    int unsigned                 kind_seen[5];
    int unsigned                 max_burst;

    function new();
      hold     = selm_pkg::MODE_FREE;
      sharers  = '0;
      wq_head  = 0;
      wq_count = 0;
      own_rank = '0;
      errors   = 0;
      requests_seen = 0;
      results_seen  = 0;
      max_burst     = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void queue_result(selm_pkg::kind_e kind, logic [PW-1:0] peer,
                               logic [SW-1:0] serial);
      lock_result_t res;
      res.kind     = kind;
      res.peer     = peer;
      res.serial   = serial;
      res.is_local = (peer == own_rank);
      res.pad      = 1'b0;
      res.last     = 1'b0;
      pending_results.push_back(res);
    endfunction

    // new holder of the lock; the sharer count saturates
    function void seat_holder(logic excl);
      if (excl) begin
        hold = selm_pkg::MODE_EXCL;
      end else begin
        hold = selm_pkg::MODE_SHARED;
        if (sharers < selm_pkg::SHARER_MAX) sharers++;
      end
    endfunction

    function void apply_request(lock_req_t r);
      int unsigned first;
      int unsigned slot;
      logic        ok;
      logic        freed;
      logic        head_excl;
      first = pending_results.size();
      requests_seen++;
      if (r.func == FUNC_LOCK) begin
        ok = r.excl ? (hold == selm_pkg::MODE_FREE) : (hold != selm_pkg::MODE_EXCL);
        if (ok) begin
          seat_holder(r.excl);
          queue_result(selm_pkg::KIND_GRANT, r.requestor, r.serial);
        end else if (wq_count >= WAIT_DEPTH) begin
          queue_result(selm_pkg::KIND_FULL, r.requestor, r.serial);
        end else begin
          slot = (wq_head + wq_count) % WAIT_DEPTH;
          wq_peer[slot]   = r.requestor;
          wq_excl[slot]   = r.excl;
          wq_serial[slot] = r.serial;
          wq_count++;
          queue_result(selm_pkg::KIND_QUEUED, r.requestor, r.serial);
        end
      end else if (!r.settled) begin
        queue_result(selm_pkg::KIND_BLOCK, r.requestor, '0);
      end else begin
        queue_result(selm_pkg::KIND_UACK, r.requestor, '0);
        if (r.excl) begin
          freed = 1'b1;
        end else begin
          if (sharers != 0) sharers--;
          freed = (sharers == 0);
        end
        if (freed) begin
          hold = selm_pkg::MODE_FREE;
          // an exclusive head waiter is granted alone; shared ones go through until an exclusive one is at the head
          while (wq_count > 0) begin
            head_excl = wq_excl[wq_head];
            if (head_excl && hold != selm_pkg::MODE_FREE) break;
            seat_holder(head_excl);
            queue_result(selm_pkg::KIND_GRANT, wq_peer[wq_head], wq_serial[wq_head]);
            wq_head = (wq_head + 1) % WAIT_DEPTH;
            wq_count--;
            if (head_excl) break;
          end
        end
      end
      pending_results[pending_results.size()-1].last = 1'b1;
      if (pending_results.size() - first > max_burst) max_burst = pending_results.size() - first;
    endfunction

    function void compare_field(string name, logic [SW-1:0] want, logic [SW-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(lock_result_t got);
      lock_result_t want;
      results_seen++;
      if (got.kind < 5) kind_seen[got.kind]++;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: kind %0d peer %0d", got.kind, got.peer);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind",         want.kind,     got.kind);
      compare_field("peer",         want.peer,     got.peer);
      compare_field("grant_serial", want.serial,   got.serial);
      compare_field("is_local",     want.is_local, got.is_local);
      compare_field("pad",          want.pad,      got.pad);
      compare_field("last",         want.last,     got.last);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  // clock, reset and block ports
  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [PW-1:0]                   cfg_wdata;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // requestor[5:0], exclusive[6], serial[70:7], settled[71]
  logic [selm_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;   // func[0]
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // peer[5:0], serial[69:6], is_local[70], zero[71]
  logic [selm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [selm_pkg::KIND_W-1:0]     m_axis_tuser;   // kind[2:0]
  logic                            m_axis_tlast;

  lock_outcome_book book;

  // stimulus controls shared with the output side
  bit steady;         // no gaps on either side while set
  bit hold_off_req;   // asks the output side for one long stall

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  shared_exclusive_lock_manager #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic lock_req_t make_req(logic func, logic [PW-1:0] requestor, logic excl,
                                         logic [SW-1:0] serial, logic settled);
    lock_req_t r;
    r.func      = func;
    r.requestor = requestor;
    r.excl      = excl;
    r.serial    = serial;
    r.settled   = settled;
    return r;
  endfunction

  // random requestor, now and then this target's own rank so is_local gets exercised
  function automatic lock_req_t rand_req(logic func, logic excl, logic settled);
    logic [PW-1:0] requestor;
    requestor = ($urandom_range(0, 3) == 0) ? book.own_rank : PW'($urandom_range(0, 63));
    return make_req(func, requestor, excl, {$urandom, $urandom}, settled);
  endfunction

  // one request transfer; called and returns at a falling edge
  task automatic send_req(input lock_req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.settled, r.serial, r.excl, r.requestor};
    s_axis_tuser  <= r.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.apply_request(r);
    @(negedge clk_i);
  endtask

  // waits until every result is back, then lets the block go idle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_own_rank(input logic [PW-1:0] rank);
    cfg_we    <= 1'b1;
    cfg_wdata <= rank;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    book.own_rank = rank;
  endtask

  // random traffic built from short scenarios
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    int unsigned m;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
        // single lock request of either type
        send_req(rand_req(FUNC_LOCK, $urandom_range(0, 1), $urandom_range(0, 1)));
        sent++;
      end else if (pick <= 7) begin
        // unlock, mostly with settled fragments
        send_req(rand_req(FUNC_UNLOCK, $urandom_range(0, 1), $urandom_range(0, 6) != 0));
        sent++;
      end else if (pick == 8) begin
        // exclusive holder with a pile of shared waiters, then the big release
        n = $urandom_range(10, 17);
        send_req(rand_req(FUNC_LOCK, LOCK_EXCL, $urandom_range(0, 1)));
        repeat (n) send_req(rand_req(FUNC_LOCK, LOCK_SHARED, $urandom_range(0, 1)));
        send_req(rand_req(FUNC_UNLOCK, LOCK_EXCL, 1'b1));
        sent += n + 2;
      end else begin
        // exclusive contention up to and past a full queue, with a few releases
        n = $urandom_range(3, 18);
        m = $urandom_range(1, 4);
        repeat (n) send_req(rand_req(FUNC_LOCK, LOCK_EXCL, $urandom_range(0, 1)));
        repeat (m) send_req(rand_req(FUNC_UNLOCK, LOCK_EXCL, 1'b1));
        sent += n + m;
      end
    end
  endtask

  // output side: random stalls, one long hold-off on request, checks each transfer
  initial begin
    int unsigned stall_left;
    lock_result_t got;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.kind     = m_axis_tuser;
        got.peer     = m_axis_tdata[5:0];
        got.serial   = m_axis_tdata[69:6];
        got.is_local = m_axis_tdata[70];
        got.pad      = m_axis_tdata[71];
        got.last     = m_axis_tlast;
        book.match_result(got);
      end
    end
  end

  // watchdog: any cycle with a transfer on either side restarts the count
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet, book.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    book          = new();
    steady        = 1'b0;
    hold_off_req  = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_LOCK;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed walk through the lock modes and the queue
    write_own_rank(6'd2);
    send_req(make_req(FUNC_LOCK,   6'd0,  LOCK_SHARED, 64'd0, 1'b0));          // free -> shared
    send_req(make_req(FUNC_LOCK,   6'd63, LOCK_SHARED, '1, 1'b1));             // second sharer
    send_req(make_req(FUNC_LOCK,   6'd1,  LOCK_EXCL,   64'h1111, 1'b1));       // waits
    send_req(make_req(FUNC_LOCK,   6'd2,  LOCK_SHARED, 64'h2222, 1'b0));       // shared granted
    send_req(make_req(FUNC_UNLOCK, 6'd0,  LOCK_SHARED, '1, 1'b0));             // unsettled
    send_req(make_req(FUNC_UNLOCK, 6'd63, LOCK_EXCL,   64'h5a5a, 1'b0));       // unsettled
    send_req(make_req(FUNC_UNLOCK, 6'd0,  LOCK_SHARED, 64'd0, 1'b1));
    send_req(make_req(FUNC_UNLOCK, 6'd63, LOCK_SHARED, 64'd0, 1'b1));
    send_req(make_req(FUNC_UNLOCK, 6'd2,  LOCK_SHARED, '1, 1'b1));             // grants excl
    send_req(make_req(FUNC_LOCK,   6'd5,  LOCK_SHARED, 64'h8000_0000_0000_0005, 1'b1));
    send_req(make_req(FUNC_LOCK,   6'd6,  LOCK_EXCL,   64'h6, 1'b0));
    send_req(make_req(FUNC_LOCK,   6'd7,  LOCK_SHARED, 64'h7, 1'b1));
    send_req(make_req(FUNC_LOCK,   6'd8,  LOCK_SHARED, 64'h8, 1'b0));
    send_req(make_req(FUNC_UNLOCK, 6'd1,  LOCK_EXCL,   64'd0, 1'b1));          // stops at excl
    send_req(make_req(FUNC_UNLOCK, 6'd5,  LOCK_SHARED, 64'd0, 1'b1));          // excl granted
    send_req(make_req(FUNC_UNLOCK, 6'd6,  LOCK_EXCL,   64'd0, 1'b1));          // two shared
    send_req(make_req(FUNC_UNLOCK, 6'd7,  LOCK_SHARED, 64'd0, 1'b1));
    send_req(make_req(FUNC_UNLOCK, 6'd8,  LOCK_SHARED, 64'd0, 1'b1));
    send_req(make_req(FUNC_UNLOCK, 6'd9,  LOCK_SHARED, 64'd0, 1'b1));          // sharers at zero
    send_req(make_req(FUNC_LOCK,   6'd2,  LOCK_EXCL,   64'hdead_beef, 1'b1));  // local grant
    send_req(make_req(FUNC_UNLOCK, 6'd2,  LOCK_SHARED, 64'd0, 1'b1));          // shared of excl
    wait_idle();

    // random traffic under changing own_rank settings and idle patterns
    write_own_rank(6'd63);
    run_random(25);
    wait_idle();

    write_own_rank(6'd0);
    steady = 1'b1;   // no gaps on either side
    run_random(25);
    steady = 1'b0;
    wait_idle();

    write_own_rank(PW'($urandom_range(1, 62)));
    hold_off_req = 1'b1;   // output stalls long while requests keep coming
    run_random(35);
    wait_idle();

    // sharer count saturation: release until no exclusive hold or waiter is left, then pile up shared holders
    write_own_rank(PW'($urandom_range(0, 63)));
    while (book.wq_count > 0 || book.hold == selm_pkg::MODE_EXCL) begin
      send_req(rand_req(FUNC_UNLOCK, LOCK_EXCL, 1'b1));
    end
    repeat (130) send_req(rand_req(FUNC_LOCK, LOCK_SHARED, $urandom_range(0, 1)));
    send_req(rand_req(FUNC_UNLOCK, LOCK_SHARED, 1'b1));
    send_req(rand_req(FUNC_UNLOCK, LOCK_EXCL, 1'b1));

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run covered %0d requests and %0d results, up to %0d results per request",
             book.requests_seen, book.results_seen, book.max_burst);
    $display("grants %0d, unlock acks %0d, queued %0d, would-block %0d, queue-full %0d",
             book.kind_seen[selm_pkg::KIND_GRANT], book.kind_seen[selm_pkg::KIND_UACK],
             book.kind_seen[selm_pkg::KIND_QUEUED], book.kind_seen[selm_pkg::KIND_BLOCK],
             book.kind_seen[selm_pkg::KIND_FULL]);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      if (book.pending() != 0) $error("%0d expected results never arrived", book.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
